/* rtl/core/pcg_pkg.sv */
`default_nettype none
package pcg_pkg;

	localparam logic [1:0] CMD_SEED = 2'd0;
	localparam logic [1:0] CMD_INT  = 2'd1;
	localparam logic [1:0] CMD_FRAC = 2'd2;

	localparam logic [31:0] MUL_LO = 32'h4C95_7F2D;
	localparam logic [31:0] MUL_HI = 32'h5851_F42D;
	localparam logic [63:0] INC    = 64'd105;

	localparam int unsigned XS_SHIFT_A = 18;
	localparam int unsigned XS_SHIFT_B = 27;
	localparam int unsigned ROT_SHIFT  = 59;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LL,
		S_LH,
		S_HL,
		S_FIN,
		S_SPAN,
		S_SPANFIN,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} seq_ctl_t;

	typedef struct packed {
		logic ready;
		logic done;
	} seq_sts_t;

	// XSH-RR output permutation of the pre-step state
	function automatic logic [31:0] pcg_word(input logic [63:0] s);
		logic [63:0] mix;
		logic [31:0] xs;
		logic [4:0]  rot;
		mix = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
		xs  = mix[31:0];
		rot = 5'(s >> ROT_SHIFT);
		return (xs >> rot) | (xs << (5'd0 - rot));
	endfunction

endpackage
`default_nettype wire

/* rtl/core/pcg_mul32.sv */
`default_nettype none
module pcg_mul32 (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

endmodule
`default_nettype wire

/* rtl/core/pcg_seq.sv */
`default_nettype none
module pcg_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pcg_pkg::seq_ctl_t ctl,
	input  wire logic [1:0]       command,
	input  wire logic [63:0]      seed_value,
	input  wire logic [31:0]      range_low,
	input  wire logic [31:0]      range_high,
	output pcg_pkg::seq_sts_t     sts,
	output logic      [31:0]      int_q,
	output logic      [63:0]      frac_q
);

	pcg_pkg::seq_state_t fsm_q, fsm_d;

	logic [63:0] gen_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [1:0]  cmd_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [31:0] word0_q;
	logic        second_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;
	logic [63:0] step_new;

	pcg_mul32 u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign step_new = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

	always_comb begin
		mul_a = x_q[31:0];
		mul_b = pcg_pkg::MUL_LO;
		case (fsm_q)
			pcg_pkg::S_LH: begin
				mul_b = pcg_pkg::MUL_HI;
			end
			pcg_pkg::S_HL: begin
				mul_a = x_q[63:32];
			end
			pcg_pkg::S_SPAN: begin
				mul_a = span_q;
				mul_b = word0_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= pcg_pkg::S_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		sts.ready = 1'b0;
		sts.done  = 1'b0;
		unique case (fsm_q)
			pcg_pkg::S_IDLE: begin
				sts.ready = 1'b1;
				if (ctl.start) begin
					unique case (command)
						pcg_pkg::CMD_SEED,
						pcg_pkg::CMD_INT,
						pcg_pkg::CMD_FRAC: fsm_d = pcg_pkg::S_LL;
						default:           fsm_d = pcg_pkg::S_DONE;
					endcase
				end
			end
			pcg_pkg::S_LL:  fsm_d = pcg_pkg::S_LH;
			pcg_pkg::S_LH:  fsm_d = pcg_pkg::S_HL;
			pcg_pkg::S_HL:  fsm_d = pcg_pkg::S_FIN;
			pcg_pkg::S_FIN: begin
				if (cmd_q == pcg_pkg::CMD_INT) begin
					fsm_d = pcg_pkg::S_SPAN;
				end else if (cmd_q == pcg_pkg::CMD_FRAC && !second_q) begin
					fsm_d = pcg_pkg::S_LL;
				end else begin
					fsm_d = pcg_pkg::S_DONE;
				end
			end
			pcg_pkg::S_SPAN:    fsm_d = pcg_pkg::S_SPANFIN;
			pcg_pkg::S_SPANFIN: fsm_d = pcg_pkg::S_DONE;
			pcg_pkg::S_DONE: begin
				sts.done = 1'b1;
				if (ctl.ack) begin
					fsm_d = pcg_pkg::S_IDLE;
				end
			end
			default: fsm_d = pcg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= 64'd0;
		end else if (fsm_q == pcg_pkg::S_FIN) begin
			gen_q <= step_new;
		end
	end

	always_ff @(posedge clk) begin
		case (fsm_q)
			pcg_pkg::S_IDLE: begin
				if (ctl.start) begin
					cmd_q    <= command;
					lo_q     <= range_low;
					span_q   <= range_high - range_low + 32'd1;
					int_q    <= 32'd0;
					frac_q   <= 64'd0;
					second_q <= 1'b0;
					word0_q  <= pcg_pkg::pcg_word(gen_q);
					if (command == pcg_pkg::CMD_SEED) begin
						x_q <= seed_value + pcg_pkg::INC;
					end else begin
						x_q <= gen_q;
					end
				end
			end
			pcg_pkg::S_LH: begin
				acc_q <= prod_q + pcg_pkg::INC;
			end
			pcg_pkg::S_HL: begin
				acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			end
			pcg_pkg::S_FIN: begin
				if (cmd_q == pcg_pkg::CMD_FRAC) begin
					if (!second_q) begin
						frac_q[31:0] <= word0_q;
						second_q     <= 1'b1;
						x_q          <= step_new;
					end else begin
						frac_q[63:32] <= pcg_pkg::pcg_word(x_q);
					end
				end
			end
			pcg_pkg::S_SPANFIN: begin
				int_q <= lo_q + prod_q[63:32];
			end
			default: begin
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> fsm_q == pcg_pkg::S_IDLE)
		else $error("start outside idle");

	a_int_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == pcg_pkg::S_DONE && cmd_q != pcg_pkg::CMD_INT) |-> int_q == 32'd0)
		else $error("integer result set for non-integer command");

	a_frac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == pcg_pkg::S_DONE && cmd_q != pcg_pkg::CMD_FRAC) |-> frac_q == 64'd0)
		else $error("fraction result set for non-fraction command");

	a_span_seq: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == pcg_pkg::S_SPAN |=> fsm_q == pcg_pkg::S_SPANFIN)
		else $error("span multiply not followed by finish");

endmodule
`default_nettype wire

/* rtl/core/pcg32_range_random_generator_top.sv */
// PCG32 XSH-RR random source with ranged integer and 0.64 fraction draws.
// Input stream: tuser carries the command (0 seed, 1 integer draw, 2 fraction
// draw, 3 no-op); tdata carries seed_value, range_low, range_high.
// Output stream: one item per input item; tdata carries integer_value and
// fraction_value, the field not used by the command is zero.
// All 64-bit state arithmetic runs on one registered 32x32 multiplier that
// the sequencer steps through three partial products per LCG step.
// Per item the sequencer runs the LCG step for a seed; the step and then the
// range multiply for an integer draw; the step and then a second step for
// a fraction draw; nothing for a no-op. tready is high only while the
// sequencer is idle, so one item is in work at a time.
// The finished item moves to an output register; the next item is accepted
// while it waits. If the receiver stalls, the following result holds inside
// the sequencer until the output register frees up.
// Reset clears the generator state to zero and empties the output register.
`default_nettype none
module pcg32_range_random_generator_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // seed_value, range_low, range_high
	input  wire logic [1:0]   s_axis_tuser,  // command
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [95:0]  m_axis_tdata   // integer_value, fraction_value
);

	pcg_pkg::seq_ctl_t ctl;
	pcg_pkg::seq_sts_t sts;
	logic [31:0] int_q;
	logic [63:0] frac_q;
	logic        out_valid_q;
	logic [95:0] out_data_q;

	assign s_axis_tready = sts.ready;
	assign ctl.start     = s_axis_tvalid && sts.ready;
	assign ctl.ack       = sts.done && (!out_valid_q || m_axis_tready);

	pcg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.command    (s_axis_tuser),
		.seed_value (s_axis_tdata[63:0]),
		.range_low  (s_axis_tdata[95:64]),
		.range_high (s_axis_tdata[127:96]),
		.sts        (sts),
		.int_q      (int_q),
		.frac_q     (frac_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ack) begin
			out_data_q <= {frac_q, int_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0]  CMD_NOP     = 2'd3;
	localparam logic [63:0] LCG_MUL     = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] LCG_INC     = 64'd105;
	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          RANDOM_ITEMS = 1750;
	localparam int          MAX_REPORTS = 20;

	typedef struct packed {
		logic [31:0] integer_value;
		logic [63:0] fraction_value;
	} draw_result_t;

	class draw_scoreboard;
		logic [63:0]  gen_state;
		draw_result_t pending[$];
		int           errors;
		int           checked;
		int           cmd_count[4];

		function new();
			gen_state = '0;
			errors = 0;
			checked = 0;
			foreach (cmd_count[i]) cmd_count[i] = 0;
		endfunction

		// XSH-RR word from the state before the LCG step
		function logic [31:0] next_word();
			logic [63:0] s;
			logic [63:0] mix;
			logic [31:0] xs;
			logic [4:0]  rot;
			logic [63:0] rotated;
			s = gen_state;
			gen_state = s * LCG_MUL + LCG_INC;
			mix = ((s >> 18) ^ s) >> 27;
			xs = mix[31:0];
			rot = s[63:59];
			rotated = {xs, xs} >> rot;
			return rotated[31:0];
		endfunction

		function void note_command(logic [1:0] cmd, logic [63:0] seed, logic [31:0] lo,
				logic [31:0] hi);
			draw_result_t r;
			logic [31:0]  span;
			logic [63:0]  prod;
			logic [31:0]  w0;
			logic [31:0]  w1;
			r = '0;
			cmd_count[cmd]++;
			case (cmd)
				pcg_pkg::CMD_SEED: gen_state = (LCG_INC + seed) * LCG_MUL + LCG_INC;
				pcg_pkg::CMD_INT: begin
					span = hi - lo + 32'd1;
					prod = {32'd0, span} * {32'd0, next_word()};
					r.integer_value = lo + prod[63:32];
				end
				pcg_pkg::CMD_FRAC: begin
					w0 = next_word();
					w1 = next_word();
					r.fraction_value = {w1, w0};
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_output(logic [95:0] data);
			draw_result_t exp_r;
			draw_result_t got;
			got.integer_value = data[31:0];
			got.fraction_value = data[95:32];
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected item int=%0d frac=%h", $time,
						$signed(got.integer_value), got.fraction_value);
				return;
			end
			exp_r = pending.pop_front();
			if (got.integer_value !== exp_r.integer_value) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: integer_value expected %0d got %0d", $time,
						$signed(exp_r.integer_value), $signed(got.integer_value));
			end
			if (got.fraction_value !== exp_r.fraction_value) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: fraction_value expected %h got %h", $time,
						exp_r.fraction_value, got.fraction_value);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;  // seed_value, range_low, range_high
	logic [1:0]   s_axis_tuser;  // command
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;  // integer_value, fraction_value

	draw_scoreboard sb = new();
	bit             no_gaps;
	int unsigned    cycle_count = 0;
	int             rx_stall_left;

	pcg32_range_random_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding", cycle_count,
				sb.pending.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls
	initial begin
		m_axis_tready = 1'b0;
		rx_stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_stall_left > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 3) == 0)
					rx_stall_left = pick_gap();
			end
		end
	end

	// called at a falling edge, returns at a falling edge after the item is taken
	task automatic send_item(logic [1:0] cmd, logic [63:0] seed, logic [31:0] lo,
			logic [31:0] hi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {hi, lo, seed};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(cmd, seed, lo, hi);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int          r;
		logic [1:0]  cmd;
		logic [63:0] seed;
		logic [31:0] lo;
		logic [31:0] hi;
		r = $urandom_range(0, 19);
		if (r < 2)
			cmd = pcg_pkg::CMD_SEED;
		else if (r < 11)
			cmd = pcg_pkg::CMD_INT;
		else if (r < 18)
			cmd = pcg_pkg::CMD_FRAC;
		else
			cmd = CMD_NOP;
		seed = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: begin
				lo = $urandom();
				hi = $urandom();
			end
			1: begin
				lo = $urandom();
				hi = lo + $urandom_range(0, 15);
			end
			2: begin
				lo = 32'h8000_0000;
				hi = 32'h7FFF_FFFF;
			end
			3: begin
				lo = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				hi = $urandom();
			end
			default: begin
				lo = -$urandom_range(0, 1000);
				hi = $urandom_range(0, 1000);
			end
		endcase
		send_item(cmd, seed, lo, hi);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = pcg_pkg::CMD_SEED;
		no_gaps = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// draws from the reset state, then seeds and range corner cases
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd0, 32'd99);
		send_item(pcg_pkg::CMD_FRAC, 64'd0, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_SEED, 64'd0, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd0, 32'hFFFF_FFFF);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd42, 32'd42);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'h8000_0000, 32'h8000_0000);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd5, -32'sd5);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(pcg_pkg::CMD_INT,  64'd0, -32'sd100, 32'd100);
		send_item(pcg_pkg::CMD_FRAC, 64'd0, 32'd0, 32'd0);
		send_item(CMD_NOP,  64'd0, 32'd0, 32'd0);
		send_item(CMD_NOP,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(pcg_pkg::CMD_FRAC, 64'd0, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_item(pcg_pkg::CMD_FRAC, 64'd0, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(pcg_pkg::CMD_SEED, 64'h8000_0000_0000_0000, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd0, 32'd1);
		send_item(pcg_pkg::CMD_SEED, 64'hFFFF_FFFF_FFFF_FF97, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_FRAC, 64'd0, 32'd0, 32'd0);
		send_item(pcg_pkg::CMD_INT,  64'd0, 32'd1, 32'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_random_item();
		end
		s_axis_tvalid <= 1'b0;
		no_gaps = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("seeds %0d, integer draws %0d, fraction draws %0d, no-ops %0d",
			sb.cmd_count[pcg_pkg::CMD_SEED], sb.cmd_count[pcg_pkg::CMD_INT],
			sb.cmd_count[pcg_pkg::CMD_FRAC], sb.cmd_count[CMD_NOP]);
		$display("%0d results checked, %0d mismatches, %0d cycles", sb.checked,
			sb.errors, cycle_count);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
